FILE: design/cspp_pkg.sv
// ---------------------------------------------------------------------------
// cspp_pkg
// Shared types and constants for the CAN signal payload packer: request and
// result payloads, controller states, and controller/datapath handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

package cspp_pkg;

	// default payload size in bytes
	localparam int PAYLOAD_BYTES_DEF = 8;

	// widths of the request fields
	localparam int RAW_W   = 64;
	localparam int START_W = 6;
	localparam int LEN_W   = 7;
	localparam int POS_W   = 8;
	localparam int SRC_W   = 6;

	// longest signal that raw_value can hold
	localparam logic [LEN_W-1:0] LEN_MAX = 7'd64;

	// motorola walk jump at a byte boundary
	localparam logic [POS_W-1:0] MOTO_JUMP = 8'd15;

	typedef struct packed {
		logic [RAW_W-1:0]   raw_value;
		logic [START_W-1:0] start_bit;
		logic [LEN_W-1:0]   bit_length;
		logic               little_endian;
		logic               last_signal;
	} sig_t;

	typedef struct packed {
		logic [RAW_W-1:0] payload;
		logic             spilled;
	} frame_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic flush;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic len_zero;
		logic final_step;
		logic last_q;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

FILE: design/cspp_ctrl.sv
// ---------------------------------------------------------------------------
// cspp_ctrl
// Controller for the payload packer: takes a request, walks its bits one per
// cycle and, for the last signal, hands the payload to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module cspp_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               sig_valid,
	input  wire               sig_last,
	output logic              sig_stall,
	input  cspp_pkg::status_t status,
	output cspp_pkg::cmd_t    cmd
);
	import cspp_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sig_valid) begin
					if (!status.len_zero) begin
						state_nxt = ST_WALK;
					end else if (sig_last) begin
						state_nxt = ST_FLUSH;
					end
				end
			end
			ST_WALK: begin
				if (status.final_step) begin
					state_nxt = status.last_q ? ST_FLUSH : ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (status.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		sig_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				sig_stall = 1'b0;
				cmd.load  = sig_valid;
			end
			ST_WALK: begin
				cmd.step = 1'b1;
			end
			ST_FLUSH: begin
				cmd.flush = status.out_free;
			end
			default: begin
				sig_stall = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: design/cspp_dp.sv
// ---------------------------------------------------------------------------
// cspp_dp
// Datapath for the payload packer: holds the current signal, the walk
// position and source index, the payload buffer, and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module cspp_dp #(
	parameter int PAYLOAD_BYTES = cspp_pkg::PAYLOAD_BYTES_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  cspp_pkg::sig_t     sig,
	input  cspp_pkg::cmd_t     cmd,
	output cspp_pkg::status_t  status,
	output logic               frame_valid,
	input  wire                frame_stall,
	output cspp_pkg::frame_t   frame
);
	import cspp_pkg::*;

	localparam logic [POS_W-1:0] LIMIT = POS_W'(PAYLOAD_BYTES * 8);

	logic [RAW_W-1:0] raw_q;
	logic [POS_W-1:0] pos_q;
	logic [LEN_W-1:0] cnt_q;
	logic [SRC_W-1:0] src_q;
	logic             intel_q;
	logic             last_q;
	logic [RAW_W-1:0] buffer_q;
	logic             spill_q;
	frame_t           out_q;
	logic             out_valid_q;

	logic [LEN_W-1:0] len_sat;
	logic [POS_W-1:0] pos_nxt;
	logic             bit_v;
	logic             in_range;

	// length saturates at 64
	assign len_sat = sig.bit_length[6] ? LEN_MAX : sig.bit_length;

	// current signal bit and where the walk goes next
	assign bit_v    = raw_q[src_q];
	assign in_range = pos_q < LIMIT;
	always_comb begin
		if (intel_q) begin
			pos_nxt = pos_q + POS_W'(1);
		end else if (pos_q[2:0] == 3'd0) begin
			pos_nxt = pos_q + MOTO_JUMP;
		end else begin
			pos_nxt = pos_q - POS_W'(1);
		end
	end

	// signal registers, loaded on request and advanced per step
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			raw_q   <= sig.raw_value;
			pos_q   <= POS_W'(sig.start_bit);
			cnt_q   <= len_sat;
			src_q   <= sig.little_endian ? '0 : SRC_W'(len_sat - LEN_W'(1));
			intel_q <= sig.little_endian;
			last_q  <= sig.last_signal;
		end else if (cmd.step) begin
			pos_q <= pos_nxt;
			cnt_q <= cnt_q - LEN_W'(1);
			src_q <= intel_q ? src_q + SRC_W'(1) : src_q - SRC_W'(1);
		end
	end

	// payload buffer and spill flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_q <= '0;
			spill_q  <= 1'b0;
		end else if (cmd.flush) begin
			buffer_q <= '0;
			spill_q  <= 1'b0;
		end else if (cmd.step) begin
			if (in_range) begin
				if (bit_v) begin
					buffer_q[pos_q[SRC_W-1:0]] <= 1'b1;
				end
			end else begin
				spill_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.flush) begin
			out_valid_q <= 1'b1;
		end else if (!frame_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.flush) begin
			out_q.payload <= buffer_q;
			out_q.spilled <= spill_q;
		end
	end

	assign frame_valid       = out_valid_q;
	assign frame             = out_q;
	assign status.len_zero   = (sig.bit_length == '0);
	assign status.final_step = (cnt_q == LEN_W'(1));
	assign status.last_q     = last_q;
	assign status.out_free   = !out_valid_q || !frame_stall;

endmodule

`default_nettype wire

FILE: design/can_signal_payload_pack_core.sv
// Sequence: load in idle, walk the bits (bit_length saturates at 64), and on
// a frame's last signal flush the payload once the output register is free.
// Throughput: one request at a time; the bit walk places one bit per cycle.
// The output register lets the next request start while a payload waits.
// Reset: arst_n clears the controller, payload buffer, spill flag and output.
// ---------------------------------------------------------------------------
// can_signal_payload_pack_core
// Packs CAN signals in Intel or Motorola byte order into a payload buffer and
// emits the finished payload with a spill flag on the last signal of a frame.
// ---------------------------------------------------------------------------
`default_nettype none

module can_signal_payload_pack_core #(
	parameter int PAYLOAD_BYTES = cspp_pkg::PAYLOAD_BYTES_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               sig_valid,
	output logic              sig_stall,
	input  cspp_pkg::sig_t    sig,
	output logic              frame_valid,
	input  wire               frame_stall,
	output cspp_pkg::frame_t  frame
);
	import cspp_pkg::*;

	localparam int LIMIT_BITS = PAYLOAD_BYTES * 8;
	localparam logic [RAW_W-1:0] HI_MASK =
		(LIMIT_BITS >= RAW_W) ? '0 : ~((RAW_W'(1) << LIMIT_BITS) - RAW_W'(1));

	cmd_t    cmd;
	status_t status;

	cspp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.sig_valid (sig_valid),
		.sig_last  (sig.last_signal),
		.sig_stall (sig_stall),
		.status    (status),
		.cmd       (cmd)
	);

	cspp_dp #(
		.PAYLOAD_BYTES (PAYLOAD_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.sig         (sig),
		.cmd         (cmd),
		.status      (status),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame       (frame)
	);

	// a payload never has bits beyond its size
	a_no_high_bits: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid |-> ((frame.payload & HI_MASK) == '0))
		else $error("payload bit set beyond payload size");

	// handover only into a free output register
	a_flush_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> (!frame_valid || !frame_stall))
		else $error("payload handed over while output busy");

	// no request is taken while the walk runs
	a_step_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> sig_stall)
		else $error("request taken during bit walk");

	// controller commands are exclusive
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.step, cmd.flush}))
		else $error("conflicting datapath commands");

endmodule

`default_nettype wire
